### src/command_packet_type3_framer_unit_defines.svh
// Assertion macros for the type-3 packet framer.
// Depends on i_clk and i_rst_n being visible where the macros are used.
`ifndef COMMAND_PACKET_TYPE3_FRAMER_UNIT_DEFINES_SVH
`define COMMAND_PACKET_TYPE3_FRAMER_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define CP3F_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("framer check failed");

// Check a consequence in the same cycle as its cause
`define CP3F_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// Check a consequence in the cycle after its cause
`define CP3F_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

### src/cp3f_pkg.sv
// Shared types and constants of the type-3 packet framer.
// No dependencies; used by every module of the block.
package cp3f_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISALIGNED = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    // the only supported packet type
    localparam logic [1:0] PKT_TYPE3 = 2'd3;
    // byte phase that completes a word
    localparam logic [1:0] LAST_PHASE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             kind;
        logic [31:0]            data_word;
        logic [OFFSET_BITS-1:0] word_pos;
        logic [1:0]             status;
        logic [1:0]             pkt_type;
        logic [7:0]             opcode;
        logic [13:0]            count_field;
        logic [7:0]             low_control;
        logic [14:0]            total_words;
        logic [14:0]            words_needed;
        logic [OFFSET_BITS-1:0] words_avail;
        logic                   packet_end;
    } t_out_item;

    // results caused by one input item: a word result, an end status, or both
    typedef struct packed {
        logic      word_valid;
        logic      stat_valid;
        t_out_item word;
        t_out_item stat;
    } t_push;

    typedef struct packed {
        logic [FIFO_CNT_BITS-1:0] level;
        logic                     full;
    } t_queue_status;

endpackage

### src/cp3f_core.sv
// Framing state machine: word assembly, packet tracking and error hold.
// Depends on cp3f_pkg; feeds cp3f_queue with the results of each item.
module cp3f_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  cp3f_pkg::t_in_item i_item,
    output cp3f_pkg::t_push    o_push
);
    import cp3f_pkg::*;

    logic [1:0]             r_phase,      n_phase;
    logic [23:0]            r_partial,    n_partial;
    logic                   r_in_packet,  n_in_packet;
    logic [14:0]            r_body_rem,   n_body_rem;
    logic [OFFSET_BITS-1:0] r_words_seen, n_words_seen;
    logic [OFFSET_BITS-1:0] r_pkt_start,  n_pkt_start;
    logic [14:0]            r_pkt_len,    n_pkt_len;
    logic                   r_err_valid,  n_err_valid;
    logic [OFFSET_BITS-1:0] r_err_offset, n_err_offset;
    logic [1:0]             r_err_type,   n_err_type;
    logic [OFFSET_BITS-1:0] r_err_avail,  n_err_avail;

    logic [31:0] word;
    logic [13:0] count;
    logic [1:0]  hdr_type;
    t_push       push;

    assign word     = {i_item.data_byte, r_partial};
    assign count    = word[29:16];
    assign hdr_type = word[31:30];

    // advance the framing state by one byte and build its results
    always_comb begin
        n_phase      = r_phase;
        n_partial    = r_partial;
        n_in_packet  = r_in_packet;
        n_body_rem   = r_body_rem;
        n_words_seen = r_words_seen;
        n_pkt_start  = r_pkt_start;
        n_pkt_len    = r_pkt_len;
        n_err_valid  = r_err_valid;
        n_err_offset = r_err_offset;
        n_err_type   = r_err_type;
        n_err_avail  = r_err_avail;
        push         = '0;

        if (r_phase != LAST_PHASE) begin
            // gather a byte, little-endian
            n_phase = r_phase + 2'd1;
            case (r_phase)
                2'd0:    n_partial[7:0]   = i_item.data_byte;
                2'd1:    n_partial[15:8]  = i_item.data_byte;
                2'd2:    n_partial[23:16] = i_item.data_byte;
                default: n_partial        = r_partial;
            endcase
        end else begin
            n_phase      = '0;
            n_partial    = '0;
            n_words_seen = r_words_seen + OFFSET_BITS'(1);
            if (r_err_valid) begin
                // after an error, count words but frame none
                n_err_avail = r_err_avail + OFFSET_BITS'(1);
            end else if (!r_in_packet) begin
                push.word_valid       = 1'b1;
                push.word.kind        = KIND_HEADER;
                push.word.data_word   = word;
                push.word.word_pos    = r_words_seen;
                push.word.pkt_type    = hdr_type;
                push.word.opcode      = word[15:8];
                push.word.count_field = count;
                push.word.low_control = word[7:0];
                if (hdr_type != PKT_TYPE3) begin
                    push.word.status = ST_BAD_TYPE;
                    n_err_valid      = 1'b1;
                    n_err_offset     = r_words_seen;
                    n_err_type       = hdr_type;
                    n_err_avail      = OFFSET_BITS'(1);
                end else begin
                    push.word.status      = ST_OK;
                    push.word.total_words = {1'b0, count} + 15'd2;
                    n_in_packet           = 1'b1;
                    n_body_rem            = {1'b0, count} + 15'd1;
                    n_pkt_start           = r_words_seen;
                    n_pkt_len             = {1'b0, count} + 15'd2;
                end
            end else begin
                push.word_valid       = 1'b1;
                push.word.kind        = KIND_BODY;
                push.word.data_word   = word;
                push.word.word_pos    = r_words_seen;
                push.word.pkt_type    = PKT_TYPE3;
                push.word.total_words = r_pkt_len;
                push.word.packet_end  = (r_body_rem == 15'd1);
                if (r_body_rem <= 15'd1) begin
                    n_body_rem  = '0;
                    n_in_packet = 1'b0;
                end else begin
                    n_body_rem = r_body_rem - 15'd1;
                end
            end
        end

        // end of buffer: report in priority order, then clear all
        if (i_item.end_of_buffer) begin
            push.stat_valid = 1'b1;
            push.stat.kind  = KIND_END;
            if (n_phase != 2'd0) begin
                push.stat.status = ST_MISALIGNED;
            end else if (n_err_valid) begin
                push.stat.status       = ST_BAD_TYPE;
                push.stat.word_pos     = n_err_offset;
                push.stat.pkt_type     = n_err_type;
                push.stat.words_needed = 15'd1;
                push.stat.words_avail  = n_err_avail;
            end else if (n_in_packet) begin
                push.stat.status       = ST_TRUNCATED;
                push.stat.word_pos     = n_pkt_start;
                push.stat.pkt_type     = PKT_TYPE3;
                push.stat.words_needed = n_pkt_len;
                push.stat.words_avail  = n_words_seen - n_pkt_start;
            end else begin
                push.stat.status   = ST_OK;
                push.stat.word_pos = n_words_seen;
            end
            n_phase      = '0;
            n_partial    = '0;
            n_in_packet  = 1'b0;
            n_body_rem   = '0;
            n_words_seen = '0;
            n_pkt_start  = '0;
            n_pkt_len    = '0;
            n_err_valid  = 1'b0;
            n_err_offset = '0;
            n_err_type   = '0;
            n_err_avail  = '0;
        end
    end

    // hold the state; advance only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_partial    <= '0;
            r_in_packet  <= 1'b0;
            r_body_rem   <= '0;
            r_words_seen <= '0;
            r_pkt_start  <= '0;
            r_pkt_len    <= '0;
            r_err_valid  <= 1'b0;
            r_err_offset <= '0;
            r_err_type   <= '0;
            r_err_avail  <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_partial    <= n_partial;
            r_in_packet  <= n_in_packet;
            r_body_rem   <= n_body_rem;
            r_words_seen <= n_words_seen;
            r_pkt_start  <= n_pkt_start;
            r_pkt_len    <= n_pkt_len;
            r_err_valid  <= n_err_valid;
            r_err_offset <= n_err_offset;
            r_err_type   <= n_err_type;
            r_err_avail  <= n_err_avail;
        end
    end

    // push only when the item caused at least one result
    always_comb begin
        o_push            = push;
        o_push.word_valid = push.word_valid & i_accept;
        o_push.stat_valid = push.stat_valid & i_accept;
    end

endmodule

### src/cp3f_queue.sv
// Result queue: holds per-item result pairs and hands them out one by one.
// Depends on cp3f_pkg; fed by cp3f_core.
module cp3f_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cp3f_pkg::t_push         i_push,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output cp3f_pkg::t_out_item     o_out_data,
    output cp3f_pkg::t_queue_status o_status
);
    import cp3f_pkg::*;

    t_push                    r_entry [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic                     r_sub;
    logic [FIFO_CNT_BITS-1:0] n_count;

    t_push head;
    logic  push;
    logic  take;
    logic  pop;
    logic  show_word;

    assign head      = r_entry[r_rd_ptr];
    assign push      = i_push.word_valid | i_push.stat_valid;
    assign show_word = head.word_valid & ~r_sub;
    assign take      = o_out_valid & ~i_out_stall;
    // drop the head once its last result has gone
    assign pop       = take & ~(show_word & head.stat_valid);
    assign n_count   = r_count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);

    assign o_out_valid     = (r_count != '0);
    assign o_out_data      = show_word ? head.word : head.stat;
    assign o_status.level  = r_count;
    assign o_status.full   = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));

    // store result pairs
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push;
        end
    end

    // advance pointers and the word/status sub-position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(1);
            end
            if (take) begin
                r_sub <= ~pop;
            end
            r_count <= n_count;
        end
    end

endmodule

### src/command_packet_type3_framer_unit.sv
// Type-3 command packet framer, one byte per item, one item per cycle unless stalled.
// Results are registered in a four-entry queue and offered in order from its head.
// Throughput: one item per cycle; an item may cause up to two results, which leave
// one per cycle unless the output stalls; the queue stalls input when full.
// Reset: synchronous, active low; clears framing state and empties the queue.
`include "command_packet_type3_framer_unit_defines.svh"

module command_packet_type3_framer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cp3f_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cp3f_pkg::t_out_item o_out_data
);
    import cp3f_pkg::*;

    logic          in_accept;
    t_push         push;
    t_queue_status q_status;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // framing state and result generation
    cp3f_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (push)
    );

    // result queue towards the output channel
    cp3f_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_status    (q_status)
    );

    // queue never overfills
    `CP3F_ASSERT_ALWAYS(a_level_bound, q_status.level <= FIFO_CNT_BITS'(FIFO_DEPTH))
    // output is offered exactly while the queue holds results
    `CP3F_ASSERT_ALWAYS(a_valid_level, o_out_valid == (q_status.level != '0))
    // an accepted last byte always leaves a status to deliver
    `CP3F_ASSERT_NEXT(a_end_seen, in_accept && i_in_data.end_of_buffer, o_out_valid)
    // a status result always carries the end kind
    `CP3F_ASSERT_SAME(a_push_kind, push.stat_valid, push.stat.kind == KIND_END)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the type-3 command packet framer: streams byte buffers and checks each result.
// Depends on cp3f_pkg and command_packet_type3_framer_unit; predicts results in-line.
module tb;
    import cp3f_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP = 40;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    command_packet_type3_framer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Framing state of the predictor
    logic [1:0]  fr_phase;
    logic [23:0] fr_partial;
    logic        fr_in_packet;
    logic [14:0] fr_body_left;
    logic [23:0] fr_words_seen;
    logic [23:0] fr_packet_start;
    logic [14:0] fr_packet_len;
    logic        fr_err_valid;
    logic [23:0] fr_err_offset;
    logic [1:0]  fr_err_type;
    logic [23:0] fr_err_avail;

    t_out_item   pending_frames[$];
    logic [7:0]  cmd_bytes[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          steady_flow = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the result side at random, except in steady stretches
    always @(posedge i_clk) begin
        i_out_stall <= !steady_flow && ($urandom_range(99) < 33);
    end

    function automatic void clear_framer();
        fr_phase        = '0;
        fr_partial      = '0;
        fr_in_packet    = 1'b0;
        fr_body_left    = '0;
        fr_words_seen   = '0;
        fr_packet_start = '0;
        fr_packet_len   = '0;
        fr_err_valid    = 1'b0;
        fr_err_offset   = '0;
        fr_err_type     = '0;
        fr_err_avail    = '0;
    endfunction

    // Frame one completed word: header, body, or silently counted after an error
    function automatic void frame_word(logic [31:0] w);
        t_out_item r;
        r = '0;
        if (fr_err_valid) begin
            fr_err_avail = fr_err_avail + 24'd1;
        end else if (!fr_in_packet) begin
            r.kind        = KIND_HEADER;
            r.data_word   = w;
            r.word_pos    = fr_words_seen;
            r.pkt_type    = w[31:30];
            r.opcode      = w[15:8];
            r.count_field = w[29:16];
            r.low_control = w[7:0];
            if (w[31:30] != PKT_TYPE3) begin
                r.status      = ST_BAD_TYPE;
                fr_err_valid  = 1'b1;
                fr_err_offset = fr_words_seen;
                fr_err_type   = w[31:30];
                fr_err_avail  = 24'd1;
            end else begin
                r.status        = ST_OK;
                r.total_words   = 15'(w[29:16]) + 15'd2;
                fr_in_packet    = 1'b1;
                fr_body_left    = 15'(w[29:16]) + 15'd1;
                fr_packet_start = fr_words_seen;
                fr_packet_len   = r.total_words;
            end
            pending_frames = {pending_frames, r};
        end else begin
            r.kind        = KIND_BODY;
            r.data_word   = w;
            r.word_pos    = fr_words_seen;
            r.status      = ST_OK;
            r.pkt_type    = PKT_TYPE3;
            r.total_words = fr_packet_len;
            r.packet_end  = (fr_body_left == 15'd1);
            if (fr_body_left <= 15'd1) begin
                fr_body_left = '0;
                fr_in_packet = 1'b0;
            end else begin
                fr_body_left = fr_body_left - 15'd1;
            end
            pending_frames = {pending_frames, r};
        end
        fr_words_seen = fr_words_seen + 24'd1;
    endfunction

    // Work out the end-of-buffer status in priority order
    function automatic t_out_item buffer_status();
        t_out_item r;
        r = '0;
        r.kind = KIND_END;
        if (fr_phase != 2'd0) begin
            r.status = ST_MISALIGNED;
        end else if (fr_err_valid) begin
            r.status       = ST_BAD_TYPE;
            r.word_pos     = fr_err_offset;
            r.pkt_type     = fr_err_type;
            r.words_needed = 15'd1;
            r.words_avail  = fr_err_avail;
        end else if (fr_in_packet) begin
            r.status       = ST_TRUNCATED;
            r.word_pos     = fr_packet_start;
            r.pkt_type     = PKT_TYPE3;
            r.words_needed = fr_packet_len;
            r.words_avail  = fr_words_seen - fr_packet_start;
        end else begin
            r.status   = ST_OK;
            r.word_pos = fr_words_seen;
        end
        return r;
    endfunction

    // Advance the predictor by one accepted byte
    function automatic void frame_byte(t_in_item it);
        if (fr_phase != LAST_PHASE) begin
            fr_partial = fr_partial | (24'(it.data_byte) << (8 * fr_phase));
            fr_phase   = fr_phase + 2'd1;
        end else begin
            frame_word({it.data_byte, fr_partial});
            fr_phase   = '0;
            fr_partial = '0;
        end
        if (it.end_of_buffer) begin
            pending_frames = {pending_frames, buffer_status()};
            clear_framer();
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // Compare one result with the oldest prediction
    task automatic check_frame(t_out_item got);
        t_out_item want;
        if (pending_frames.size() == 0) begin
            report_mismatch("result with nothing pending, kind", 32'(got.kind), 32'(KIND_END));
        end else begin
            want = pending_frames.pop_front();
            check_field("kind", 32'(got.kind), 32'(want.kind));
            check_field("data_word", got.data_word, want.data_word);
            check_field("word_pos", 32'(got.word_pos), 32'(want.word_pos));
            check_field("status", 32'(got.status), 32'(want.status));
            check_field("pkt_type", 32'(got.pkt_type), 32'(want.pkt_type));
            check_field("opcode", 32'(got.opcode), 32'(want.opcode));
            check_field("count_field", 32'(got.count_field), 32'(want.count_field));
            check_field("low_control", 32'(got.low_control), 32'(want.low_control));
            check_field("total_words", 32'(got.total_words), 32'(want.total_words));
            check_field("words_needed", 32'(got.words_needed),
                        32'(want.words_needed));
            check_field("words_avail", 32'(got.words_avail),
                        32'(want.words_avail));
            check_field("packet_end", 32'(got.packet_end), 32'(want.packet_end));
        end
    endtask

    // Check results first, then predict from the item taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_frame(o_out_data);
            if (i_in_valid && !o_in_stall) frame_byte(i_in_data);
        end
    end

    // Offer one byte, idling at random first, and hold it until taken
    task automatic send_byte(logic [7:0] b, logic last);
        t_in_item it;
        it.data_byte     = b;
        it.end_of_buffer = last;
        while (!steady_flow && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_buffer();
        foreach (cmd_bytes[i]) send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
        cmd_bytes.delete();
    endtask

    // Append a word least significant byte first
    task automatic put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) cmd_bytes = {cmd_bytes, w[8*i +: 8]};
    endtask

    function automatic logic [31:0] make_header(logic [1:0] ptype, logic [13:0] count,
                                                logic [7:0] opc, logic [7:0] lowc);
        return {ptype, count, opc, lowc};
    endfunction

    task automatic put_packet(int count);
        put_word(make_header(PKT_TYPE3, 14'(count), 8'($urandom), 8'($urandom)));
        repeat (count + 1) put_word($urandom);
    endtask

    // Build one buffer: mostly whole packets, then a clean end or a broken tail
    task automatic build_random_buffer();
        int count;
        int pick;
        pick = $urandom_range(99);
        repeat ($urandom_range(1, 4)) begin
            count = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 7);
            put_packet(count);
        end
        if (pick >= 70 && pick < 78) begin
            // cut a packet short
            count = $urandom_range(0, 16383);
            put_word(make_header(PKT_TYPE3, 14'(count), 8'($urandom), 8'($urandom)));
            repeat ($urandom_range(0, count < 3 ? count : 3)) put_word($urandom);
        end else if (pick >= 78 && pick < 86) begin
            // drop in a header of the wrong type, then trailing words
            put_word(make_header(2'($urandom_range(0, 2)), 14'($urandom), 8'($urandom),
                                 8'($urandom)));
            repeat ($urandom_range(0, 3)) put_word($urandom);
        end else if (pick >= 86 && pick < 94) begin
            // leave a partial word
            repeat ($urandom_range(1, 3)) cmd_bytes = {cmd_bytes, 8'($urandom)};
        end else if (pick >= 94) begin
            // pure noise
            cmd_bytes.delete();
            repeat ($urandom_range(1, 12)) cmd_bytes = {cmd_bytes, 8'($urandom)};
        end
        if (pick >= 70 && pick < 86 && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) cmd_bytes = {cmd_bytes, 8'($urandom)};
    endtask

    task automatic test_directed();
        // whole minimal packet; last byte completes a body word and ends the buffer
        put_word(make_header(PKT_TYPE3, 14'd0, 8'hFF, 8'h00));
        put_word(32'hFFFF_FFFF);
        send_buffer();
        // unsupported type; the following word is only counted
        put_word(make_header(2'd0, 14'h3FFF, 8'h00, 8'hFF));
        put_word(32'h0000_0000);
        send_buffer();
        // largest count, buffer ends after the header
        put_word(make_header(PKT_TYPE3, 14'h3FFF, 8'hA5, 8'h5A));
        send_buffer();
        // buffer ends mid-word
        cmd_bytes = '{8'h12, 8'h34, 8'h56};
        send_buffer();
        cmd_bytes = '{8'h80};
        send_buffer();
    endtask

    task automatic test_random_buffers(int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            build_random_buffer();
            send_buffer();
        end
    endtask

    task automatic test_back_to_back(int n_items);
        steady_flow = 1'b1;
        test_random_buffers(n_items);
        steady_flow = 1'b0;
    endtask

    initial begin
        clear_framer();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_buffers(950);
        test_back_to_back(200);
        test_random_buffers(180);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### command_packet_type3_framer_unit.f
+incdir+src
src/cp3f_pkg.sv
src/cp3f_core.sv
src/cp3f_queue.sv
src/command_packet_type3_framer_unit.sv
tb/sv/tb.sv
